// ===== src/pmst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pmst_pkg;

    localparam int OP_W    = 1;
    localparam int VTX_W   = 4;
    localparam int EW_W    = 16;
    localparam int COUNT_W = 5;

    localparam int VCOUNT_RESET = 16;

    localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
    localparam logic [OP_W-1:0] OP_RUN  = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [VTX_W-1:0] row_vertex;
        logic [VTX_W-1:0] col_vertex;
        logic [EW_W-1:0]  edge_weight;
    } pmst_in_t;

    typedef struct packed {
        logic [VTX_W-1:0] parent_vertex;
        logic [VTX_W-1:0] child_vertex;
        logic             last_edge;
    } pmst_out_t;

    // broadcast strobes from the sequencer to every cell
    typedef struct packed {
        logic init;
        logic relax;
        logic commit;
    } pmst_ctl_t;

endpackage

`default_nettype wire

// ===== src/pmst_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pmst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/pmst_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pmst_cell #(
    parameter int VW  = 4,
    parameter int CW  = 5,
    parameter int WB  = 16,
    parameter int IDX = 1
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire pmst_pkg::pmst_ctl_t  ctl,
    input  wire logic [VW-1:0]        bus_col,
    input  wire logic [VW-1:0]        bus_k,
    input  wire logic [WB-1:0]        bus_w,
    input  wire logic [CW-1:0]        n,
    input  wire logic                 tok_in_valid,
    input  wire logic [WB-1:0]        tok_in_low,
    input  wire logic [VW-1:0]        tok_in_idx,
    input  wire logic [VW-1:0]        tok_in_par,
    output logic                      tok_out_valid,
    output logic      [WB-1:0]        tok_out_low,
    output logic      [VW-1:0]        tok_out_idx,
    output logic      [VW-1:0]        tok_out_par
);

    import pmst_pkg::*;

    localparam logic [VW-1:0] MY_IDX = VW'(IDX);
    localparam logic [CW-1:0] MY_CNT = CW'(IDX);

    logic [WB-1:0] cost_reg;
    logic [VW-1:0] parent_reg;
    logic          in_tree_reg;
    logic          tok_valid_reg;
    logic [WB-1:0] tok_low_reg;
    logic [VW-1:0] tok_idx_reg;
    logic [VW-1:0] tok_par_reg;

    logic active;
    logic hit;
    logic take;

    assign active = MY_CNT < n;
    assign hit    = bus_col == MY_IDX;
    // strict compare keeps the lowest index on a tie, the token runs upward
    assign take   = active && !in_tree_reg && (cost_reg < tok_in_low);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_tree_reg   <= 1'b0;
            tok_valid_reg <= 1'b0;
        end else begin
            tok_valid_reg <= tok_in_valid;
            if (ctl.init && hit) begin
                in_tree_reg <= 1'b0;
            end else if (ctl.commit && bus_k == MY_IDX) begin
                in_tree_reg <= 1'b1;
            end
        end

        if (ctl.init && hit) begin
            cost_reg   <= bus_w;
            parent_reg <= '0;
        end else if (ctl.relax && hit && !in_tree_reg && bus_w < cost_reg) begin
            cost_reg   <= bus_w;
            parent_reg <= bus_k;
        end

        if (take) begin
            tok_low_reg <= cost_reg;
            tok_idx_reg <= MY_IDX;
            tok_par_reg <= parent_reg;
        end else begin
            tok_low_reg <= tok_in_low;
            tok_idx_reg <= tok_in_idx;
            tok_par_reg <= tok_in_par;
        end
    end

    assign tok_out_valid = tok_valid_reg;
    assign tok_out_low   = tok_low_reg;
    assign tok_out_idx   = tok_idx_reg;
    assign tok_out_par   = tok_par_reg;

endmodule

`default_nettype wire

// ===== src/prim_minimum_spanning_tree_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Load request: accepted one per cycle while the block is idle, no result.
// Run request with n vertices: costs are first seeded from row 0; each edge then takes a
// search, the token crossing the cell chain, an emit and, for every edge after the first,
// a relax pass over the row of the vertex just joined; an emit waits while a result is
// held.
// Synchronous active-low reset clears control, tree flags and sets the count to 16
// (clamped); the weight matrix is not cleared.

module prim_minimum_spanning_tree_top #(
    parameter int MAX_VERTICES = 16,
    parameter int WEIGHT_BITS  = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire pmst_pkg::pmst_in_t              s_payload,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output pmst_pkg::pmst_out_t                  m_payload,
    input  wire logic                            cfg_we,
    input  wire logic [pmst_pkg::COUNT_W-1:0]    cfg_wdata
);

    import pmst_pkg::*;

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int CW    = $clog2(MAX_VERTICES + 1);
    localparam int AW    = 2 * VW;
    localparam int DEPTH = 1 << AW;
    localparam int WB    = WEIGHT_BITS;

    localparam logic [WB-1:0] NO_EDGE = {WB{1'b1}};
    localparam logic [CW-1:0] N_MAX   = CW'(MAX_VERTICES);
    localparam logic [CW-1:0] N_MIN   = CW'(2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_RELAX,
        ST_SEARCH,
        ST_WAIT,
        ST_EMIT
    } state_t;

    function automatic logic [CW-1:0] clamp_count(input logic [COUNT_W-1:0] v);
        logic [CW-1:0] r;
        if (v < COUNT_W'(2)) begin
            r = N_MIN;
        end else if (32'(v) > MAX_VERTICES) begin
            r = N_MAX;
        end else begin
            r = CW'(v);
        end
        return r;
    endfunction

    state_t        state_reg;
    logic [CW-1:0] n_reg;
    logic [VW-1:0] col_reg;
    logic [CW-1:0] round_reg;
    logic [VW-1:0] k_reg;
    logic [VW-1:0] par_reg;
    logic          rd_valid_reg;
    logic          rd_init_reg;
    logic [VW-1:0] rd_col_reg;
    logic          inject_reg;
    logic          m_valid_reg;
    pmst_out_t     m_payload_reg;

    logic          tok_valid [MAX_VERTICES];
    logic [WB-1:0] tok_low   [MAX_VERTICES];
    logic [VW-1:0] tok_idx   [MAX_VERTICES];
    logic [VW-1:0] tok_par   [MAX_VERTICES];

    logic          issue;
    logic          last_col;
    logic          last_round;
    logic          out_free;
    logic          emit_fire;
    logic          wr_en;
    logic [VW-1:0] rd_row;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    logic [WB-1:0] wdata;
    logic [WB-1:0] rdata;
    pmst_ctl_t     ctl;

    assign s_ready = state_reg == ST_IDLE;

    assign wr_en = s_valid && s_ready && s_payload.operation == OP_LOAD
                   && 32'(s_payload.row_vertex) < MAX_VERTICES
                   && 32'(s_payload.col_vertex) < MAX_VERTICES;
    assign waddr = {VW'(s_payload.row_vertex), VW'(s_payload.col_vertex)};
    assign wdata = WB'(s_payload.edge_weight);

    // seeding reads row 0, each round after reads the row of the vertex just joined
    assign issue      = state_reg == ST_INIT || state_reg == ST_RELAX;
    assign rd_row     = (state_reg == ST_INIT) ? '0 : k_reg;
    assign raddr      = {rd_row, col_reg};
    assign last_col   = CW'(col_reg) == n_reg - CW'(1);
    assign last_round = round_reg == n_reg - CW'(1);
    assign out_free   = !m_valid_reg || m_ready;
    assign emit_fire  = state_reg == ST_EMIT && out_free;

    assign ctl.init   = rd_valid_reg && rd_init_reg;
    assign ctl.relax  = rd_valid_reg && !rd_init_reg;
    assign ctl.commit = emit_fire;

    pmst_ram #(
        .WIDTH (WB),
        .DEPTH (DEPTH)
    ) u_matrix (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (waddr),
        .wdata (wdata),
        .re    (issue),
        .raddr (raddr),
        .rdata (rdata)
    );

    // head of the chain: a fresh search token
    assign tok_valid[0] = inject_reg;
    assign tok_low[0]   = NO_EDGE;
    assign tok_idx[0]   = '0;
    assign tok_par[0]   = '0;

    for (genvar i = 1; i < MAX_VERTICES; i++) begin : g_cell
        pmst_cell #(
            .VW  (VW),
            .CW  (CW),
            .WB  (WB),
            .IDX (i)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .ctl           (ctl),
            .bus_col       (rd_col_reg),
            .bus_k         (k_reg),
            .bus_w         (rdata),
            .n             (n_reg),
            .tok_in_valid  (tok_valid[i-1]),
            .tok_in_low    (tok_low[i-1]),
            .tok_in_idx    (tok_idx[i-1]),
            .tok_in_par    (tok_par[i-1]),
            .tok_out_valid (tok_valid[i]),
            .tok_out_low   (tok_low[i]),
            .tok_out_idx   (tok_idx[i]),
            .tok_out_par   (tok_par[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            n_reg        <= clamp_count(COUNT_W'(VCOUNT_RESET));
            rd_valid_reg <= 1'b0;
            inject_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                n_reg <= clamp_count(cfg_wdata);
            end
            rd_valid_reg <= issue;
            rd_init_reg  <= state_reg == ST_INIT;
            rd_col_reg   <= col_reg;
            inject_reg   <= state_reg == ST_SEARCH;
            if (m_valid_reg && m_ready && !emit_fire) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_payload.operation == OP_RUN) begin
                        state_reg <= ST_INIT;
                        col_reg   <= VW'(1);
                        round_reg <= CW'(1);
                    end
                end
                ST_INIT, ST_RELAX: begin
                    col_reg <= col_reg + VW'(1);
                    if (last_col) begin
                        state_reg <= ST_SEARCH;
                    end
                end
                ST_SEARCH: begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (tok_valid[MAX_VERTICES-1]) begin
                        k_reg     <= tok_idx[MAX_VERTICES-1];
                        par_reg   <= tok_par[MAX_VERTICES-1];
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_valid_reg                 <= 1'b1;
                        m_payload_reg.parent_vertex <= VTX_W'(par_reg);
                        m_payload_reg.child_vertex  <= VTX_W'(k_reg);
                        m_payload_reg.last_edge     <= last_round;
                        round_reg                   <= round_reg + CW'(1);
                        if (last_round) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            state_reg <= ST_RELAX;
                            col_reg   <= VW'(1);
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

`ifndef SYNTHESIS
    // the search token only leaves the chain while the sequencer waits for it
    a_tok_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        tok_valid[MAX_VERTICES-1] |-> state_reg == ST_WAIT)
        else $error("search token left the chain outside the wait state");

    // all relax updates land before a search starts
    a_relax_before_search: assert property (@(posedge aclk) disable iff (!aresetn)
        inject_reg |-> !rd_valid_reg)
        else $error("search injected while a row update is still pending");

    a_ctl_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({ctl.init, ctl.relax, ctl.commit}))
        else $error("cell strobes overlap");

    // no load lands in the matrix while a run is walking it
    a_no_write_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        issue |-> !wr_en)
        else $error("matrix written during a run");
`endif

endmodule

`default_nettype wire

// ===== test/tb_prim_minimum_spanning_tree_top.sv =====
`timescale 1ns / 1ps

module tb_prim_minimum_spanning_tree_top;

    import pmst_pkg::*;

    localparam int NV            = 16;
    localparam logic [EW_W-1:0] NO_EDGE = {EW_W{1'b1}};
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_ITEMS  = 60;
    localparam int CYCLE_LIMIT   = 400000;

    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    pmst_in_t            s_payload = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    pmst_out_t           m_payload;
    logic                cfg_we    = 1'b0;
    logic [COUNT_W-1:0]  cfg_wdata = '0;

    // shadow of the block: weights, which entries hold a value, live count
    logic [EW_W-1:0]     weights [NV][NV];
    bit                  loaded  [NV][NV];
    logic [COUNT_W-1:0]  vertex_count_reg = COUNT_W'(VCOUNT_RESET);

    pmst_out_t           edges_due [$];
    pmst_out_t           want;
    int                  mismatches    = 0;
    int                  requests_sent = 0;
    int                  burst_left    = 0;
    int                  cycle_count   = 0;
    logic [10:0]         sink_tick     = '0;
    int unsigned         sink_hold     = 0;

    prim_minimum_spanning_tree_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int live_vertices();
        if (vertex_count_reg < 2) return 2;
        if (vertex_count_reg > NV) return NV;
        return int'(vertex_count_reg);
    endfunction

    // Prim's method from vertex 0; membership kept apart from cost so zero weights work
    function automatic void grow_tree();
        int              n;
        int              k;
        logic [EW_W-1:0] low;
        logic [EW_W-1:0] cost [NV];
        logic [3:0]      from [NV];
        bit              joined [NV];
        pmst_out_t       tree_edge;
        n = live_vertices();
        joined[0] = 1'b1;
        cost[0]   = '0;
        from[0]   = '0;
        for (int v = 1; v < n; v++) begin
            joined[v] = 1'b0;
            cost[v]   = weights[0][v];
            from[v]   = '0;
        end
        for (int round = 1; round < n; round++) begin
            low = NO_EDGE;
            k   = 0;
            for (int j = 1; j < n; j++) begin
                if (!joined[j] && cost[j] < low) begin
                    low = cost[j];
                    k   = j;
                end
            end
            // nothing reachable: k stays 0 and the round still counts
            tree_edge.parent_vertex = from[k];
            tree_edge.child_vertex  = 4'(k);
            tree_edge.last_edge     = (round == n - 1);
            edges_due.push_back(tree_edge);
            joined[k] = 1'b1;
            for (int j = 1; j < n; j++) begin
                if (!joined[j] && weights[k][j] < cost[j]) begin
                    cost[j] = weights[k][j];
                    from[j] = 4'(k);
                end
            end
        end
    endfunction

    function automatic void apply_request(input pmst_in_t req);
        if (req.operation == OP_LOAD) begin
            weights[req.row_vertex][req.col_vertex] = req.edge_weight;
            loaded[req.row_vertex][req.col_vertex]  = 1'b1;
        end else begin
            grow_tree();
        end
    endfunction

    function automatic logic [EW_W-1:0] pick_weight();
        case ($urandom_range(0, 9))
            0, 1:    return NO_EDGE;
            2:       return '0;
            3, 4, 5: return EW_W'($urandom_range(0, 7));
            6:       return NO_EDGE - 1'b1;
            default: return EW_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic int pick_count();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1);
            1:       return $urandom_range(17, 31);
            2:       return $urandom_range(9, 16);
            default: return $urandom_range(2, 8);
        endcase
    endfunction

    // bursts of requests with random gaps; valid is left high for the next request
    task automatic send_request(input pmst_in_t req);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_payload <= req;
        s_valid   <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_request(req);
        requests_sent++;
    endtask

    task automatic load_weight(input int r, input int c, input logic [EW_W-1:0] w);
        pmst_in_t req;
        req.operation   = OP_LOAD;
        req.row_vertex  = 4'(r);
        req.col_vertex  = 4'(c);
        req.edge_weight = w;
        send_request(req);
    endtask

    // every entry a run may read: rows 0..n-1, columns 1..n-1
    task automatic fill_missing(input int n);
        int pending [$];
        int pick;
        int cell_id;
        for (int r = 0; r < n; r++)
            for (int c = 1; c < n; c++)
                if (!loaded[r][c]) pending.push_back(r * NV + c);
        while (pending.size() > 0) begin
            pick    = $urandom_range(0, pending.size() - 1);
            cell_id = pending[pick];
            pending.delete(pick);
            load_weight(cell_id / NV, cell_id % NV, pick_weight());
        end
    endtask

    task automatic request_tree();
        pmst_in_t req;
        fill_missing(live_vertices());
        req.operation   = OP_RUN;
        req.row_vertex  = 4'($urandom_range(0, 15));
        req.col_vertex  = 4'($urandom_range(0, 15));
        req.edge_weight = EW_W'($urandom_range(0, 65535));
        send_request(req);
    endtask

    task automatic finish_outstanding();
        s_valid <= 1'b0;
        burst_left = 0;
        while (edges_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_vertex_count(input int value);
        finish_outstanding();
        cfg_we    <= 1'b1;
        cfg_wdata <= COUNT_W'(value);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        vertex_count_reg = COUNT_W'(value);
    endtask

    task automatic test_two_vertex_graph();
        write_vertex_count(0);
        load_weight(0, 1, NO_EDGE);
        load_weight(1, 1, 0);
        request_tree();
        write_vertex_count(1);
        load_weight(0, 1, 0);
        request_tree();
    endtask

    task automatic test_ties_and_zero_weights();
        write_vertex_count(4);
        load_weight(0, 1, 7);
        load_weight(0, 2, 0);
        load_weight(0, 3, 0);
        load_weight(1, 1, 0);
        load_weight(1, 2, NO_EDGE - 1'b1);
        load_weight(1, 3, 1);
        load_weight(2, 1, 7);
        load_weight(2, 2, 0);
        load_weight(2, 3, 0);
        load_weight(3, 1, 0);
        load_weight(3, 2, 5);
        load_weight(3, 3, NO_EDGE);
        load_weight(15, 15, NO_EDGE);
        request_tree();
    endtask

    task automatic test_unreachable_vertex();
        write_vertex_count(3);
        load_weight(0, 1, 3);
        load_weight(0, 2, NO_EDGE);
        load_weight(1, 2, NO_EDGE);
        request_tree();
    endtask

    task automatic test_random_graphs();
        int start;
        int n;
        start = requests_sent;
        while (requests_sent - start < RANDOM_ITEMS) begin
            write_vertex_count(pick_count());
            n = live_vertices();
            repeat ($urandom_range(1, 3)) begin
                repeat ($urandom_range(0, 2 * n)) begin
                    if ($urandom_range(0, 7) == 0)
                        load_weight($urandom_range(0, 15), $urandom_range(0, 15),
                                    pick_weight());
                    else
                        load_weight($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                                    pick_weight());
                end
                request_tree();
            end
        end
    endtask

    task automatic test_full_graph();
        write_vertex_count(31);
        request_tree();
        repeat (8) load_weight($urandom_range(0, 15), $urandom_range(1, 15), pick_weight());
        request_tree();
        write_vertex_count(16);
        request_tree();
    endtask

    // result side stalls on a slowly changing pattern of its own
    always @(posedge aclk) begin
        sink_tick <= sink_tick + 1'b1;
        case (sink_tick[10:9])
            2'd0: m_ready <= 1'b1;
            2'd1: m_ready <= 1'($urandom_range(0, 1));
            2'd2: m_ready <= (sink_tick[2:0] == 3'd0);
            default: begin
                if (sink_hold == 0) begin
                    m_ready   <= ~m_ready;
                    sink_hold <= $urandom_range(0, 10);
                end else begin
                    sink_hold <= sink_hold - 1;
                end
            end
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (edges_due.size() == 0) begin
                $error("tree edge with none due: parent %0d child %0d last %0d",
                       m_payload.parent_vertex, m_payload.child_vertex,
                       m_payload.last_edge);
                mismatches++;
            end else begin
                want = edges_due.pop_front();
                if (m_payload.parent_vertex !== want.parent_vertex) begin
                    $error("parent_vertex: expected %0d, got %0d",
                           want.parent_vertex, m_payload.parent_vertex);
                    mismatches++;
                end
                if (m_payload.child_vertex !== want.child_vertex) begin
                    $error("child_vertex: expected %0d, got %0d",
                           want.child_vertex, m_payload.child_vertex);
                    mismatches++;
                end
                if (m_payload.last_edge !== want.last_edge) begin
                    $error("last_edge: expected %0d, got %0d",
                           want.last_edge, m_payload.last_edge);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_two_vertex_graph();
        test_ties_and_zero_weights();
        test_unreachable_vertex();
        test_random_graphs();
        test_full_graph();
        finish_outstanding();
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
